// ===== sv/svpwm_pkg.sv =====
// ----------------------------------------------------------------------------
// svpwm_pkg
// Shared types, command codes and fixed-point constants of the SVPWM duty
// generator.
// ----------------------------------------------------------------------------
package svpwm_pkg;

   // Datapath operation codes issued by the controller.
   localparam logic [3:0] OP_NOP     = 4'd0;
   localparam logic [3:0] OP_LOAD    = 4'd1;
   localparam logic [3:0] OP_INIT    = 4'd2;
   localparam logic [3:0] OP_ROT     = 4'd3;
   localparam logic [3:0] OP_HMUL    = 4'd4;
   localparam logic [3:0] OP_VOLT    = 4'd5;
   localparam logic [3:0] OP_VZERO   = 4'd6;
   localparam logic [3:0] OP_DUTY    = 4'd7;
   localparam logic [3:0] OP_CMUL    = 4'd8;
   localparam logic [3:0] OP_CDIV    = 4'd9;
   localparam logic [3:0] OP_CSTORE  = 4'd10;
   localparam logic [3:0] OP_PUBLISH = 4'd11;

   // Configuration register indexes.
   localparam logic CSR_MAGNITUDE = 1'b0;
   localparam logic CSR_PERIOD    = 1'b1;

   localparam logic [14:0] MAG_RESET    = 15'd29491;
   localparam logic [15:0] PERIOD_RESET = 16'd19;

   localparam int unsigned CORDIC_STEPS = 14;

   // CORDIC gain in Q1.15, sqrt(3)/2 in Q1.15, and ceil(2^30 / 100).
   localparam logic signed [24:0] GAIN_Q15       = 25'sd19898;
   localparam logic signed [24:0] HALF_SQRT3_Q15 = 25'sd28378;
   localparam logic signed [24:0] RECIP_100      = 25'sd10737419;
   localparam int unsigned        RECIP_SHIFT    = 30;

   // Command from the controller to the datapath.
   typedef struct packed {
      logic [3:0] op;
      logic [3:0] idx;
   } cmd_type;

   // Arctangent of 2^-i in 65536-per-turn units.
   function automatic logic [13:0] atan_lut(input logic [3:0] i);
      logic [13:0] r;
      case (i)
         4'd0:    r = 14'd8192;
         4'd1:    r = 14'd4836;
         4'd2:    r = 14'd2555;
         4'd3:    r = 14'd1297;
         4'd4:    r = 14'd651;
         4'd5:    r = 14'd326;
         4'd6:    r = 14'd163;
         4'd7:    r = 14'd81;
         4'd8:    r = 14'd41;
         4'd9:    r = 14'd20;
         4'd10:   r = 14'd10;
         4'd11:   r = 14'd5;
         4'd12:   r = 14'd3;
         4'd13:   r = 14'd1;
         default: r = 14'd0;
      endcase
      return r;
   endfunction

endpackage

// ===== sv/svpwm_ctrl.sv =====
// ----------------------------------------------------------------------------
// svpwm_ctrl
// Sequencer of the duty generator: walks one word through load, CORDIC,
// phase voltages, duty and compare scaling, then hands it to the output.
// ----------------------------------------------------------------------------
module svpwm_ctrl
   import svpwm_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_tvalid,
   output logic    req_tready,
   output logic    rsp_tvalid,
   input  logic    rsp_tready,
   output cmd_type cmd
);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_INIT   = 4'd1;
   localparam logic [3:0] ST_ROT    = 4'd2;
   localparam logic [3:0] ST_HMUL   = 4'd3;
   localparam logic [3:0] ST_VOLT   = 4'd4;
   localparam logic [3:0] ST_VZERO  = 4'd5;
   localparam logic [3:0] ST_DUTY   = 4'd6;
   localparam logic [3:0] ST_CMUL   = 4'd7;
   localparam logic [3:0] ST_CDIV   = 4'd8;
   localparam logic [3:0] ST_CSTORE = 4'd9;
   localparam logic [3:0] ST_DONE   = 4'd10;

   localparam logic [3:0] ROT_LAST   = 4'(CORDIC_STEPS - 1);
   localparam logic [3:0] PHASE_LAST = 4'd2;

   logic [3:0] state_ff, state_in;
   logic [3:0] cnt_ff, cnt_in;
   logic       rsp_valid_ff, rsp_valid_in;
   logic       accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign accept     = req_tvalid & req_tready;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      cmd.op   = OP_NOP;
      cmd.idx  = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.op   = OP_LOAD;
               state_in = ST_INIT;
            end
         end
         ST_INIT: begin
            cmd.op   = OP_INIT;
            cnt_in   = 4'd0;
            state_in = ST_ROT;
         end
         ST_ROT: begin
            cmd.op = OP_ROT;
            if (cnt_ff == ROT_LAST) begin
               cnt_in   = 4'd0;
               state_in = ST_HMUL;
            end else begin
               cnt_in = cnt_ff + 4'd1;
            end
         end
         ST_HMUL: begin
            cmd.op   = OP_HMUL;
            state_in = ST_VOLT;
         end
         ST_VOLT: begin
            cmd.op   = OP_VOLT;
            state_in = ST_VZERO;
         end
         ST_VZERO: begin
            cmd.op   = OP_VZERO;
            state_in = ST_DUTY;
         end
         ST_DUTY: begin
            cmd.op   = OP_DUTY;
            cnt_in   = 4'd0;
            state_in = ST_CMUL;
         end
         ST_CMUL: begin
            cmd.op   = OP_CMUL;
            state_in = ST_CDIV;
         end
         ST_CDIV: begin
            cmd.op   = OP_CDIV;
            state_in = ST_CSTORE;
         end
         ST_CSTORE: begin
            cmd.op = OP_CSTORE;
            if (cnt_ff == PHASE_LAST) begin
               cnt_in   = 4'd0;
               state_in = ST_DONE;
            end else begin
               cnt_in   = cnt_ff + 4'd1;
               state_in = ST_CMUL;
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.op   = OP_PUBLISH;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (cmd.op == OP_PUBLISH) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= 4'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // An accepted word always starts the CORDIC setup next.
   a_accept_init: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_INIT))
      else $error("accepted word did not start processing");

   // The rotation counter never runs past the last CORDIC step.
   a_rot_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ROT) |-> (cnt_ff <= ROT_LAST))
      else $error("CORDIC step counter out of range");

   // A result is never published over one that is still waiting.
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (cmd.op == OP_PUBLISH) |-> (!rsp_valid_ff || rsp_tready))
      else $error("pending result overwritten");

   // The output only becomes valid out of the hand-off state.
   a_valid_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_DONE))
      else $error("result valid raised outside hand-off");

endmodule

// ===== sv/svpwm_dpath.sv =====
// ----------------------------------------------------------------------------
// svpwm_dpath
// Datapath of the duty generator: phase accumulator, configuration
// registers, shared multiplier, CORDIC rotator and output registers.
// ----------------------------------------------------------------------------
module svpwm_dpath
   import svpwm_pkg::*;
#(
   parameter int PHASE_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata,
   input  logic [14:0] phase_step,
   input  cmd_type     cmd,
   output logic [15:0] phase,
   output logic [6:0]  duty_a,
   output logic [6:0]  duty_b,
   output logic [6:0]  duty_c,
   output logic [15:0] compare_a,
   output logic [15:0] compare_b,
   output logic [15:0] compare_c
);

   localparam int SUMW = (PHASE_BITS > 15) ? PHASE_BITS : 15;

   // Sign-magnitude-free Q.23 working widths.
   localparam int XW = 26;
   localparam int VW = 28;
   localparam int ZW = 18;

   logic [14:0]           mag_ff;
   logic [15:0]           period_ff;
   logic [PHASE_BITS-1:0] acc_ff, acc_in;
   logic [SUMW-1:0]       acc_sum;
   logic [15:0]           p16;

   logic signed [26:0]    mul_a;
   logic signed [24:0]    mul_b;
   logic signed [51:0]    mul_p;
   logic signed [51:0]    prod_ff, prod_in;

   logic signed [XW-1:0]  x_ff, x_in, y_ff, y_in, x_sh, y_sh, x0;
   logic signed [ZW-1:0]  z_ff, z_in, z_step;
   logic                  mid;

   logic signed [VW-1:0]  va_ff, vb_ff, vc_ff, va_in, vb_in, vc_in;
   logic signed [VW-1:0]  h, half, vmax, vmin, v0_ff, v0_in;
   logic signed [VW:0]    vsum;

   logic [6:0]            da_ff, db_ff, dc_ff, da_in, db_in, dc_in, dsel;
   logic [15:0]           ca_ff, cb_ff, cc_ff, ca_in, cb_in, cc_in, cval;

   logic [15:0]           o_phase_ff;
   logic [6:0]            o_da_ff, o_db_ff, o_dc_ff;
   logic [15:0]           o_ca_ff, o_cb_ff, o_cc_ff;

   // floor((v - v0 + 1.0) * 50) in Q.23, clamped to 0..100.
   function automatic logic [6:0] to_duty(input logic signed [VW-1:0] v,
                                          input logic signed [VW-1:0] z0);
      logic signed [29:0] t;
      logic signed [36:0] d;
      logic signed [36:0] q;
      logic [6:0]         r;
      t = 30'(v) - 30'(z0) + 30'sd8388608;
      d = (37'(t) <<< 5) + (37'(t) <<< 4) + (37'(t) <<< 1);
      q = d >>> 23;
      if (t < 0) begin
         r = 7'd0;
      end else if (q > 37'sd100) begin
         r = 7'd100;
      end else begin
         r = q[6:0];
      end
      return r;
   endfunction

   // Phase accumulator and the 16-bit angle taken from it.
   assign acc_sum = SUMW'(acc_ff) + SUMW'(phase_step);
   assign acc_in  = (cmd.op == OP_LOAD) ? acc_sum[PHASE_BITS-1:0] : acc_ff;

   generate
      if (PHASE_BITS >= 16) begin : g_top
         assign p16 = acc_ff[PHASE_BITS-1 -: 16];
      end else begin : g_shl
         assign p16 = {acc_ff, {(16-PHASE_BITS){1'b0}}};
      end
   endgenerate

   // Shared multiplier; its product is always registered.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (cmd.op)
         OP_LOAD: begin
            mul_a = $signed({12'd0, mag_ff});
            mul_b = GAIN_Q15;
         end
         OP_HMUL: begin
            mul_a = 27'(y_ff);
            mul_b = HALF_SQRT3_Q15;
         end
         OP_CMUL: begin
            mul_a = $signed({11'd0, period_ff});
            mul_b = $signed({18'd0, dsel});
         end
         OP_CDIV: begin
            mul_a = $signed({4'd0, prod_ff[22:0]});
            mul_b = RECIP_100;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign mul_p = mul_a * mul_b;
   assign prod_in = (cmd.op == OP_LOAD || cmd.op == OP_HMUL ||
                     cmd.op == OP_CMUL || cmd.op == OP_CDIV) ? mul_p : prod_ff;

   // CORDIC setup: angles in the left half plane rotate the negated vector.
   assign mid  = (p16[15] != p16[14]);
   assign x0   = $signed({3'd0, prod_ff[29:7]});
   assign x_sh = x_ff >>> cmd.idx;
   assign y_sh = y_ff >>> cmd.idx;
   assign z_step = $signed({4'd0, atan_lut(cmd.idx)});

   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      z_in = z_ff;
      case (cmd.op)
         OP_INIT: begin
            x_in = mid ? -x0 : x0;
            y_in = '0;
            z_in = ZW'($signed({p16[15] ^ mid, p16[14:0]}));
         end
         OP_ROT: begin
            if (z_ff >= 0) begin
               x_in = x_ff - y_sh;
               y_in = y_ff + x_sh;
               z_in = z_ff - z_step;
            end else begin
               x_in = x_ff + y_sh;
               y_in = y_ff - x_sh;
               z_in = z_ff + z_step;
            end
         end
         default: begin
            x_in = x_ff;
         end
      endcase
   end

   // Inverse Clarke and the min-max midpoint.
   assign h    = VW'(prod_ff >>> 15);
   assign half = VW'(x_ff >>> 1);

   always_comb begin
      vmax = va_ff;
      if (vb_ff > vmax) vmax = vb_ff;
      if (vc_ff > vmax) vmax = vc_ff;
      vmin = va_ff;
      if (vb_ff < vmin) vmin = vb_ff;
      if (vc_ff < vmin) vmin = vc_ff;
   end

   assign vsum  = (VW+1)'(vmax) + (VW+1)'(vmin);
   assign v0_in = (cmd.op == OP_VZERO) ? VW'(vsum >>> 1) : v0_ff;

   assign va_in = (cmd.op == OP_VOLT) ? VW'(x_ff)  : va_ff;
   assign vb_in = (cmd.op == OP_VOLT) ? -half + h  : vb_ff;
   assign vc_in = (cmd.op == OP_VOLT) ? -half - h  : vc_ff;

   assign da_in = (cmd.op == OP_DUTY) ? to_duty(va_ff, v0_ff) : da_ff;
   assign db_in = (cmd.op == OP_DUTY) ? to_duty(vb_ff, v0_ff) : db_ff;
   assign dc_in = (cmd.op == OP_DUTY) ? to_duty(vc_ff, v0_ff) : dc_ff;

   // Compare scaling runs one phase at a time, chosen by the command index.
   always_comb begin
      case (cmd.idx[1:0])
         2'd0:    dsel = da_ff;
         2'd1:    dsel = db_ff;
         default: dsel = dc_ff;
      endcase
   end

   assign cval  = prod_ff[RECIP_SHIFT+15:RECIP_SHIFT];
   assign ca_in = (cmd.op == OP_CSTORE && cmd.idx[1:0] == 2'd0) ? cval : ca_ff;
   assign cb_in = (cmd.op == OP_CSTORE && cmd.idx[1:0] == 2'd1) ? cval : cb_ff;
   assign cc_in = (cmd.op == OP_CSTORE && cmd.idx[1:0] == 2'd2) ? cval : cc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff    <= '0;
         mag_ff    <= MAG_RESET;
         period_ff <= PERIOD_RESET;
      end else begin
         acc_ff <= acc_in;
         if (csr_wr_en) begin
            case (csr_index)
               CSR_MAGNITUDE: mag_ff    <= csr_wdata[14:0];
               CSR_PERIOD:    period_ff <= csr_wdata;
               default:       mag_ff    <= mag_ff;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      x_ff    <= x_in;
      y_ff    <= y_in;
      z_ff    <= z_in;
      va_ff   <= va_in;
      vb_ff   <= vb_in;
      vc_ff   <= vc_in;
      v0_ff   <= v0_in;
      da_ff   <= da_in;
      db_ff   <= db_in;
      dc_ff   <= dc_in;
      ca_ff   <= ca_in;
      cb_ff   <= cb_in;
      cc_ff   <= cc_in;
      if (cmd.op == OP_PUBLISH) begin
         o_phase_ff <= p16;
         o_da_ff    <= da_ff;
         o_db_ff    <= db_ff;
         o_dc_ff    <= dc_ff;
         o_ca_ff    <= ca_ff;
         o_cb_ff    <= cb_ff;
         o_cc_ff    <= cc_ff;
      end
   end

   assign phase     = o_phase_ff;
   assign duty_a    = o_da_ff;
   assign duty_b    = o_db_ff;
   assign duty_c    = o_dc_ff;
   assign compare_a = o_ca_ff;
   assign compare_b = o_cb_ff;
   assign compare_c = o_cc_ff;

endmodule

// ===== sv/svpwm_duty_generator_top.sv =====
// ----------------------------------------------------------------------------
// svpwm_duty_generator_top
// Space-vector PWM duty generator with min-max zero-sequence injection.
// ----------------------------------------------------------------------------
// Each word on the req_ channel is one PWM update event carrying a phase
// step. The step is added to a wrapping phase accumulator, the modulation
// vector is rotated to the new angle by a 14-step CORDIC, the inverse Clarke
// transform gives three phase voltages, and the midpoint of their maximum
// and minimum is removed. Each phase becomes a duty percentage (0 to 100)
// and a timer compare value, period times duty over 100.
// The csr_ port writes the magnitude (index 0) and the timer period
// (index 1); write it only while no update is in flight.
// An accepted word's result is published on rsp_ after its compare values are stored, and
// the next word is taken when the controller is back in idle. The length of
// one update is set by the 14 CORDIC steps and the single shared multiplier,
// which is used in turn for gain, sqrt(3)/2 and the three compare scalings.
// The result sits in an output register, so the next word is computed while
// it waits; if rsp_tready stays low, the following result is held inside and
// req_tready stays low until the output register frees up.
// Reset clears the phase accumulator, loads the default magnitude (0.9) and
// period (19), and empties the output register.
// ----------------------------------------------------------------------------
module svpwm_duty_generator_top
   import svpwm_pkg::*;
#(
   parameter int PHASE_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   // Request channel.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [15:0] req_tdata,   // [14:0] phase_step, [15] zero
   // Result channel.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [87:0] rsp_tdata,   // [15:0] phase, [22:16] duty_a,
                                    // [29:23] duty_b, [36:30] duty_c,
                                    // [52:37] compare_a, [68:53] compare_b,
                                    // [84:69] compare_c, [87:85] zero
   // Configuration write port.
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata
);

   cmd_type     cmd;
   logic [15:0] phase;
   logic [6:0]  duty_a, duty_b, duty_c;
   logic [15:0] compare_a, compare_b, compare_c;

   // The controller sequences one word at a time and owns both handshakes.
   svpwm_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   // The datapath holds all arithmetic, the configuration registers and the
   // output register that parts the result channel from the computation.
   svpwm_dpath #(
      .PHASE_BITS (PHASE_BITS)
   ) u_dpath (
      .clock      (clock),
      .reset      (reset),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .phase_step (req_tdata[14:0]),
      .cmd        (cmd),
      .phase      (phase),
      .duty_a     (duty_a),
      .duty_b     (duty_b),
      .duty_c     (duty_c),
      .compare_a  (compare_a),
      .compare_b  (compare_b),
      .compare_c  (compare_c)
   );

   assign rsp_tdata = {3'd0, compare_c, compare_b, compare_a,
                       duty_c, duty_b, duty_a, phase};

endmodule

// ===== test/svpwm_duty_checker.sv =====
// ----------------------------------------------------------------------------
// svpwm_duty_checker
// Watches the request, result and register ports of the SVPWM duty generator.
// For every accepted request word it computes the expected update and queues
// it, and it compares every accepted result word against the oldest update in
// that queue. It reports the number of failures and of updates still pending.
// ----------------------------------------------------------------------------
module svpwm_duty_checker
   import svpwm_pkg::*;
#(
   parameter int PHASE_BITS = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [15:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [87:0] rsp_tdata,
   input  logic        csr_wr_en,
   input  logic        csr_index,
   input  logic [15:0] csr_wdata,
   output int unsigned mismatch_count,
   output int unsigned pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int unsigned REPORT_LIMIT = 10;
   localparam longint      UNIT_Q23     = 64'sd8388608;

   typedef struct packed {
      logic [15:0] phase;
      logic [6:0]  duty_a;
      logic [6:0]  duty_b;
      logic [6:0]  duty_c;
      logic [15:0] compare_a;
      logic [15:0] compare_b;
      logic [15:0] compare_c;
   } pwm_update_type;

   // Rotation angle of CORDIC step i, 65536 counts per turn.
   function automatic int cordic_angle(input int i);
      int a;
      case (i)
         0:       a = 8192;
         1:       a = 4836;
         2:       a = 2555;
         3:       a = 1297;
         4:       a = 651;
         5:       a = 326;
         6:       a = 163;
         7:       a = 81;
         8:       a = 41;
         9:       a = 20;
         10:      a = 10;
         11:      a = 5;
         12:      a = 3;
         13:      a = 1;
         default: a = 0;
      endcase
      return a;
   endfunction

   // Maps a Q.23 phase voltage to a truncated, saturated duty percentage.
   function automatic logic [6:0] voltage_to_duty(input longint v);
      longint t;
      longint d;
      t = v + UNIT_Q23;
      if (t < 0) return 7'd0;
      d = (t * 50) >>> 23;
      if (d > 100) d = 100;
      return 7'(d);
   endfunction

   // Computes the duties and compare values for one 16-bit angle.
   function automatic pwm_update_type compute_duties(input logic [15:0] angle,
                                                     input logic [14:0] mag,
                                                     input logic [15:0] period);
      longint x, y, nx, ny, h, half, va, vb, vc, vmax, vmin, v0;
      int z;
      pwm_update_type r;
      x = (longint'(mag) * 19898) >>> 7;
      y = 0;
      if (angle >= 16'd16384 && angle < 16'd49152) begin
         x = -x;
         z = int'(angle) - 32768;
      end else begin
         z = (angle < 16'd32768) ? int'(angle) : int'(angle) - 65536;
      end
      for (int i = 0; i < 14; i++) begin
         if (z >= 0) begin
            nx = x - (y >>> i);
            ny = y + (x >>> i);
            z  = z - cordic_angle(i);
         end else begin
            nx = x + (y >>> i);
            ny = y - (x >>> i);
            z  = z + cordic_angle(i);
         end
         x = nx;
         y = ny;
      end
      h    = (y * 28378) >>> 15;
      half = x >>> 1;
      va   = x;
      vb   = -half + h;
      vc   = -half - h;
      vmax = va;
      if (vb > vmax) vmax = vb;
      if (vc > vmax) vmax = vc;
      vmin = va;
      if (vb < vmin) vmin = vb;
      if (vc < vmin) vmin = vc;
      v0 = (vmax + vmin) >>> 1;
      r.phase     = angle;
      r.duty_a    = voltage_to_duty(va - v0);
      r.duty_b    = voltage_to_duty(vb - v0);
      r.duty_c    = voltage_to_duty(vc - v0);
      r.compare_a = 16'((int'(period) * int'(r.duty_a)) / 100);
      r.compare_b = 16'((int'(period) * int'(r.duty_b)) / 100);
      r.compare_c = 16'((int'(period) * int'(r.duty_c)) / 100);
      return r;
   endfunction

   logic [31:0]      phase_accum;
   logic [14:0]      magnitude;
   logic [15:0]      period;
   logic [15:0]      angle;
   pwm_update_type   pending_updates[$];
   pwm_update_type   got;
   pwm_update_type   want;
   int unsigned      failures;

   always @(posedge clock) begin
      if (reset) begin
         phase_accum = '0;
         magnitude   = MAG_RESET;
         period      = PERIOD_RESET;
         failures    = 0;
         pending_updates.delete();
      end else begin
         if (csr_wr_en) begin
            if (csr_index == CSR_MAGNITUDE) magnitude = csr_wdata[14:0];
            else if (csr_index == CSR_PERIOD) period = csr_wdata;
         end
         if (rsp_tvalid && rsp_tready) begin
            got.phase     = rsp_tdata[15:0];
            got.duty_a    = rsp_tdata[22:16];
            got.duty_b    = rsp_tdata[29:23];
            got.duty_c    = rsp_tdata[36:30];
            got.compare_a = rsp_tdata[52:37];
            got.compare_b = rsp_tdata[68:53];
            got.compare_c = rsp_tdata[84:69];
            if (pending_updates.size() == 0) begin
               if (failures < REPORT_LIMIT)
                  $display("%t: result word with no update pending: phase=%0d", $realtime,
                           got.phase);
               failures++;
            end else begin
               want = pending_updates.pop_front();
               if (got !== want) begin
                  if (failures < REPORT_LIMIT) begin
                     $display("%t: expected phase=%0d duty=%0d/%0d/%0d cmp=%0d/%0d/%0d",
                              $realtime, want.phase, want.duty_a, want.duty_b, want.duty_c,
                              want.compare_a, want.compare_b, want.compare_c);
                     $display("%t: actual   phase=%0d duty=%0d/%0d/%0d cmp=%0d/%0d/%0d",
                              $realtime, got.phase, got.duty_a, got.duty_b, got.duty_c,
                              got.compare_a, got.compare_b, got.compare_c);
                  end
                  failures++;
               end
            end
         end
         if (req_tvalid && req_tready) begin
            phase_accum = (phase_accum + 32'(req_tdata[14:0]))
                          & ((32'd1 << PHASE_BITS) - 32'd1);
            if (PHASE_BITS >= 16) angle = 16'(phase_accum >> (PHASE_BITS - 16));
            else angle = 16'(phase_accum << (16 - PHASE_BITS));
            pending_updates.push_back(compute_duties(angle, magnitude, period));
         end
      end
      mismatch_count <= failures;
      pending_count  <= pending_updates.size();
   end

endmodule

// ===== test/tb_svpwm_duty_generator_top.sv =====
// ----------------------------------------------------------------------------
// tb_svpwm_duty_generator_top
// Stimulus and verdict for the SVPWM duty generator.
// ----------------------------------------------------------------------------
// A directed run walks the quadrant boundaries, the accumulator wrap and the
// register extremes, then seven random phases of phase-step words follow,
// each under its own register setting and pacing. A checker module beside
// the block predicts every update and compares the result words.
// ----------------------------------------------------------------------------
module tb_svpwm_duty_generator_top;
   import svpwm_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          PHASE_BITS      = 16;
   localparam int unsigned RANDOM_PHASES   = 7;
   localparam int unsigned ITEMS_PER_PHASE = 150;
   // The end settle waits longer than one update takes.
   localparam int unsigned SETTLE_CYCLES   = 40;
   // Longest correct quiet stretch is a drain plus a register write plus the
   // update latency; this is many times that.
   localparam int unsigned QUIET_LIMIT     = 2000;

   typedef enum int {
      PACE_FREE,
      PACE_SENDER_IDLE,
      PACE_RECEIVER_STALL,
      PACE_BOTH
   } pace_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [15:0] req_tdata  = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [87:0] rsp_tdata;
   logic        csr_wr_en  = 1'b0;
   logic        csr_index  = 1'b0;
   logic [15:0] csr_wdata  = '0;

   int unsigned mismatch_count;
   int unsigned pending_count;

   // Percent chances, per cycle, that the sender idles or the receiver stalls.
   int unsigned send_idle_pct = 0;
   int unsigned stall_pct     = 0;

   svpwm_duty_generator_top #(
      .PHASE_BITS(PHASE_BITS)
   ) DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_wr_en  (csr_wr_en),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   svpwm_duty_checker #(
      .PHASE_BITS(PHASE_BITS)
   ) checker_inst (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_wr_en      (csr_wr_en),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .mismatch_count (mismatch_count),
      .pending_count  (pending_count)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // The receiver decides every cycle whether it takes a result word.
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // Ends the run if neither channel moves a word for too long.
   initial begin : watchdog
      int unsigned quiet;
      quiet = 0;
      while (quiet < QUIET_LIMIT) begin
         @(posedge clock);
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) quiet = 0;
         else quiet++;
      end
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   task automatic set_pace(input pace_type pace);
      case (pace)
         PACE_SENDER_IDLE: begin
            send_idle_pct = 47;
            stall_pct     = 0;
         end
         PACE_RECEIVER_STALL: begin
            send_idle_pct = 0;
            stall_pct     = 47;
         end
         PACE_BOTH: begin
            send_idle_pct = 6;
            stall_pct     = 6;
         end
         default: begin
            send_idle_pct = 0;
            stall_pct     = 0;
         end
      endcase
   endtask

   // Writes both registers back to back, magnitude first. The enable stays high
   // across the pair so it is never lowered and raised in the same step.
   task automatic set_config(input logic [15:0] mag_word, input logic [15:0] period);
      csr_wr_en <= 1'b1;
      csr_index <= CSR_MAGNITUDE;
      csr_wdata <= mag_word;
      @(posedge clock);
      csr_index <= CSR_PERIOD;
      csr_wdata <= period;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // Offers one phase-step word, after a random number of idle cycles, and
   // returns at the edge where it was accepted. Valid stays high when the
   // next word follows without a gap.
   task automatic send_step(input logic [14:0] step);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {1'b0, step};
      do @(posedge clock); while (!req_tready);
   endtask

   // Stops sending and waits until every predicted update has come back.
   // It always waits for a clock edge, so valid is never toggled within one step.
   task automatic drain_updates();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (pending_count != 0);
   endtask

   // Mostly steps in the legal range, with weight on zero, small steps and
   // the quarter-turn step; a few use the whole 15-bit field.
   function automatic logic [14:0] pick_step();
      int unsigned r;
      r = $urandom_range(99);
      if (r < 60) return 15'($urandom_range(16384));
      if (r < 75) return 15'($urandom_range(64));
      if (r < 82) return 15'd16384;
      if (r < 87) return 15'd0;
      if (r < 92) return 15'(16384 - $urandom_range(8));
      return 15'($urandom_range(32767));
   endfunction

   initial begin : stimulus
      logic [15:0] mag_word;
      logic [15:0] period;
      int unsigned hold_at;

      repeat (9) @(posedge clock);
      reset <= 1'b0;
      set_pace(PACE_FREE);

      // Reset defaults. Quarter-turn steps land exactly on every quadrant
      // boundary and then wrap the accumulator back to zero.
      send_step(15'd0);
      send_step(15'd16384);
      send_step(15'd16384);
      send_step(15'd16384);
      send_step(15'd16384);
      send_step(15'd1);
      send_step(15'd16383);
      send_step(15'd32767);
      send_step(15'd21845);
      send_step(15'd10923);

      // Full magnitude and full period; bit 15 of the magnitude word must be
      // dropped. Twelfth-turn steps hit the sector edges of the hexagon.
      drain_updates();
      set_config(16'hFFFF, 16'hFFFF);
      send_step(15'd0);
      send_step(15'd5461);
      send_step(15'd5461);
      send_step(15'd16384);
      send_step(15'd2731);
      send_step(15'd16384);

      // Period zero: every compare value collapses to zero.
      drain_updates();
      set_config(16'h7FFF, 16'h0000);
      send_step(15'd12345);
      send_step(15'd16384);
      send_step(15'd0);

      // Zero magnitude: all three duties sit at fifty percent.
      drain_updates();
      set_config(16'h8000, 16'hFFFF);
      send_step(15'd7000);
      send_step(15'd16384);

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         drain_updates();
         mag_word = {1'($urandom_range(1)), 15'($urandom_range(32767))};
         period   = $urandom_range(1) ? 16'($urandom_range(65535))
                                      : 16'($urandom_range(200));
         case (p)
            1: mag_word[14:0] = 15'h7FFF;
            2: period = 16'd0;
            4: begin
               mag_word[14:0] = 15'd0;
               period         = 16'hFFFF;
            end
            5: period = 16'hFFFF;
            default: ;
         endcase
         set_config(mag_word, period);
         set_pace(pace_type'(p % 4));
         // Somewhere inside each phase the sender waits for a full drain.
         hold_at = $urandom_range(ITEMS_PER_PHASE - 1);
         for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
            if (n == hold_at) drain_updates();
            send_step(pick_step());
         end
      end

      drain_updates();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
